// ----- sv/ipdf_pkg.sv -----
`timescale 1ns / 1ps

package ipdf_pkg;

  localparam int SCREEN_WIDTH  = 320;
  localparam int SCREEN_HEIGHT = 240;

  localparam int BORDER_W  = 7;
  localparam int INDEX_W   = 8;
  localparam int COLOR_W   = 16;
  localparam int WORD_W    = 32;
  localparam int OP_W      = 2;
  localparam int VALUE_W   = 16;
  localparam int PAL_DEPTH = 256;

  // Largest border that still leaves one row in the window
  localparam int MAX_BORDER = (SCREEN_HEIGHT - 1) / 2;
  // Pixel counter must reach the largest window size
  localparam int PIX_W = $clog2(SCREEN_WIDTH * SCREEN_HEIGHT + 1);

  localparam logic [OP_W-1:0] OP_PALETTE = 2'd0;
  localparam logic [OP_W-1:0] OP_FRAME   = 2'd1;
  localparam logic [OP_W-1:0] OP_PIXEL   = 2'd2;
  localparam logic [OP_W-1:0] OP_UNUSED  = 2'd3;

  localparam logic [7:0] CMD_COLUMN_SET   = 8'h2A;
  localparam logic [7:0] CMD_PAGE_SET     = 8'h2B;
  localparam logic [7:0] CMD_MEMORY_WRITE = 8'h2C;
  localparam logic [7:0] BYTE_MASK        = 8'hff;

  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] HDR_LAST_STEP = 4'd10;
  localparam logic [STEP_W-1:0] PIX_LAST_STEP = 4'd3;

  // Header step positions
  localparam logic [STEP_W-1:0] HS_COL_CMD  = 4'd0;
  localparam logic [STEP_W-1:0] HS_COL_S_HI = 4'd1;
  localparam logic [STEP_W-1:0] HS_COL_S_LO = 4'd2;
  localparam logic [STEP_W-1:0] HS_COL_E_HI = 4'd3;
  localparam logic [STEP_W-1:0] HS_COL_E_LO = 4'd4;
  localparam logic [STEP_W-1:0] HS_ROW_CMD  = 4'd5;
  localparam logic [STEP_W-1:0] HS_ROW_S_HI = 4'd6;
  localparam logic [STEP_W-1:0] HS_ROW_S_LO = 4'd7;
  localparam logic [STEP_W-1:0] HS_ROW_E_HI = 4'd8;
  localparam logic [STEP_W-1:0] HS_ROW_E_LO = 4'd9;
  localparam logic [STEP_W-1:0] HS_MEM_CMD  = 4'd10;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [INDEX_W-1:0] index;
    logic [COLOR_W-1:0] color;
    logic [WORD_W-1:0]  word;
  } ipdf_entry_t;

  typedef struct packed {
    logic        valid;
    ipdf_entry_t entry;
  } ipdf_head_t;

endpackage

// ----- sv/ipdf_front.sv -----
`timescale 1ns / 1ps

module ipdf_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [ipdf_pkg::OP_W-1:0]    operation,
  input  logic [ipdf_pkg::INDEX_W-1:0] palette_index,
  input  logic [ipdf_pkg::COLOR_W-1:0] palette_color,
  input  logic [ipdf_pkg::WORD_W-1:0]  pixel_word,
  output ipdf_pkg::ipdf_head_t         head,
  input  logic                         pop
);
  import ipdf_pkg::*;

  ipdf_entry_t slots [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        push;
  logic        take;

  assign in_ready = (count != 2'd2);
  // Drop the unused operation code at the door
  assign push = in_valid && in_ready && (operation != OP_UNUSED);
  assign take = pop && (count != 2'd0);

  assign head.valid = (count != 2'd0);
  assign head.entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= '{op: operation, index: palette_index,
                         color: palette_color, word: pixel_word};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (take) rd_ptr <= ~rd_ptr;
      case ({push, take})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- sv/ipdf_back.sv -----
`timescale 1ns / 1ps

module ipdf_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [ipdf_pkg::BORDER_W-1:0] border_rows,
  input  ipdf_pkg::ipdf_head_t          head,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          is_data,
  output logic                          is_pixel,
  output logic [ipdf_pkg::VALUE_W-1:0]  value,
  output logic                          frame_end,
  output logic                          last
);
  import ipdf_pkg::*;

  logic [COLOR_W-1:0] palette [PAL_DEPTH];
  logic [COLOR_W-1:0] rd_data;

  logic [STEP_W-1:0]   step;
  logic [PIX_W-1:0]    pixel_count;
  logic [PIX_W-1:0]    total_m1;
  logic [BORDER_W-1:0] border;
  logic [15:0]         row_end;
  logic [15:0]         col_end;
  logic [15:0]         rows;

  logic       advance;
  logic       pal_we;
  logic       do_frame;
  logic       do_pixel;
  logic       step_last;
  logic [7:0] hdr_byte;
  logic       hdr_data;
  logic       fend;
  logic [INDEX_W-1:0] rd_index;

  // Output register: b_* and rd_data drive the port
  logic       b_valid;
  logic       b_data;
  logic       b_pixel;
  logic [7:0] b_byte;
  logic       b_fend;
  logic       b_last;

  assign border  = (border_rows > BORDER_W'(MAX_BORDER)) ? BORDER_W'(MAX_BORDER)
                                                         : border_rows;
  assign col_end = 16'(SCREEN_WIDTH - 1);
  assign row_end = 16'(SCREEN_HEIGHT - 1) - 16'(border);
  assign rows    = 16'(SCREEN_HEIGHT) - {8'd0, border, 1'b0};

  always_ff @(posedge clk) begin
    total_m1 <= PIX_W'(PIX_W'(SCREEN_WIDTH) * PIX_W'(rows) - PIX_W'(1));
  end

  assign advance  = !b_valid || out_ready;
  assign pal_we   = head.valid && (head.entry.op == OP_PALETTE);
  assign do_frame = head.valid && (head.entry.op == OP_FRAME) && advance;
  assign do_pixel = head.valid && (head.entry.op == OP_PIXEL) && advance;
  assign step_last = (head.entry.op == OP_FRAME) ? (step == HDR_LAST_STEP)
                                                 : (step == PIX_LAST_STEP);
  assign pop = pal_we || ((do_frame || do_pixel) && step_last);

  assign rd_index = head.entry.word[{step[1:0], 3'b000} +: INDEX_W];
  assign fend     = (pixel_count >= total_m1);

  always_comb begin
    hdr_data = 1'b1;
    case (step)
      HS_COL_CMD:  begin hdr_byte = CMD_COLUMN_SET; hdr_data = 1'b0; end
      HS_COL_S_HI: hdr_byte = 8'd0;
      HS_COL_S_LO: hdr_byte = 8'd0;
      HS_COL_E_HI: hdr_byte = col_end[15:8] & BYTE_MASK;
      HS_COL_E_LO: hdr_byte = col_end[7:0] & BYTE_MASK;
      HS_ROW_CMD:  begin hdr_byte = CMD_PAGE_SET; hdr_data = 1'b0; end
      HS_ROW_S_HI: hdr_byte = 8'd0;
      HS_ROW_S_LO: hdr_byte = {1'b0, border};
      HS_ROW_E_HI: hdr_byte = row_end[15:8] & BYTE_MASK;
      HS_ROW_E_LO: hdr_byte = row_end[7:0] & BYTE_MASK;
      HS_MEM_CMD:  begin hdr_byte = CMD_MEMORY_WRITE; hdr_data = 1'b0; end
      default:     hdr_byte = 8'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pal_we) begin
      palette[head.entry.index] <= head.entry.color;
    end
  end

  // Read data holds while the output stalls
  always_ff @(posedge clk) begin
    if (do_pixel) begin
      rd_data <= palette[rd_index];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      b_data  <= do_pixel ? 1'b1 : hdr_data;
      b_pixel <= do_pixel;
      b_byte  <= hdr_byte;
      b_fend  <= do_pixel && fend;
      b_last  <= step_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step        <= '0;
      pixel_count <= '0;
      b_valid     <= 1'b0;
    end else begin
      if (advance) b_valid <= do_frame || do_pixel;
      if (do_frame || do_pixel) begin
        step <= step_last ? '0 : step + STEP_W'(1);
      end
      if (do_frame) begin
        pixel_count <= '0;
      end else if (do_pixel) begin
        pixel_count <= fend ? '0 : pixel_count + PIX_W'(1);
      end
    end
  end

  assign out_valid = b_valid;
  assign is_data   = b_data;
  assign is_pixel  = b_pixel;
  assign value     = b_pixel ? rd_data : {8'd0, b_byte};
  assign frame_end = b_fend;
  assign last      = b_last;

endmodule

// ----- sv/indexed_pixel_display_feed.sv -----
`timescale 1ns / 1ps

// Indexed pixel display feed. Items enter a two-entry queue; the back end
// gives one result per cycle via a registered output unless out_ready stalls;
// a frame start gives 11 header bytes, a pixel word 4 pixels (one read of the
// single palette read port each), a palette write none. Unused operation codes
// drop on entry. The palette holds no reset value: load every entry a frame
// uses before sending pixels. Borders above (height-1)/2 are clamped; the user
// writes border_rows (cfg_write, cfg_data) while the block is idle; unenforced.
module indexed_pixel_display_feed (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [ipdf_pkg::BORDER_W-1:0] cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ipdf_pkg::OP_W-1:0]     operation,
  input  logic [ipdf_pkg::INDEX_W-1:0]  palette_index,
  input  logic [ipdf_pkg::COLOR_W-1:0]  palette_color,
  input  logic [ipdf_pkg::WORD_W-1:0]   pixel_word,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          is_data,
  output logic                          is_pixel,
  output logic [ipdf_pkg::VALUE_W-1:0]  value,
  output logic                          frame_end,
  output logic                          last
);
  import ipdf_pkg::*;

  logic [BORDER_W-1:0] border_rows;
  ipdf_head_t          head;
  logic                pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      border_rows <= '0;
    end else if (cfg_write) begin
      border_rows <= cfg_data;
    end
  end

  ipdf_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .operation     (operation),
    .palette_index (palette_index),
    .palette_color (palette_color),
    .pixel_word    (pixel_word),
    .head          (head),
    .pop           (pop)
  );

  ipdf_back u_back (
    .clk         (clk),
    .rst         (rst),
    .border_rows (border_rows),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .is_data     (is_data),
    .is_pixel    (is_pixel),
    .value       (value),
    .frame_end   (frame_end),
    .last        (last)
  );

endmodule
